### src/indexed_priority_heap_defines.svh
// Assertion macros used by the checker of the heap block.
`ifndef INDEXED_PRIORITY_HEAP_DEFINES_SVH
`define INDEXED_PRIORITY_HEAP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define IPH_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define IPH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define IPH_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/iph_pkg.sv
package iph_pkg;

    // Size of the heap and of the node id space.
    localparam int HEAP_DEPTH = 1024;
    localparam int NODE_COUNT = 1024;

    // Field widths of the stream beats, derived from the sizes above.
    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
    localparam int FUNC_W = 3;
    localparam int STAT_W = 3;

    // Capacity after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(HEAP_DEPTH);

    // Operation codes carried in s_tuser.
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_POP    = 3'd1,
        FN_REMOVE = 3'd2,
        FN_UPDATE = 3'd3,
        FN_CLEAR  = 3'd4
    } func_t;

    // Result status codes carried in m_tuser.
    localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_PRESENT = 3'd4;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_CLR,
        CMD_LOAD,
        CMD_LOOKUP,
        CMD_CHECK,
        CMD_LAST,
        CMD_SD_RD,
        CMD_SD_CMP,
        CMD_SU_RD,
        CMD_SU_CMP,
        CMD_FIN,
        CMD_DONE
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic chk_last;
        logic chk_down;
        logic chk_up;
        logic sd_end;
        logic sd_one;
        logic sd_swap;
        logic su_top;
        logic su_swap;
        logic out_free;
    } dp_stat_t;

endpackage

### src/iph_ctrl.sv
module iph_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  iph_pkg::dp_stat_t stat,
    output iph_pkg::cmd_t    cmd
);
    import iph_pkg::*;

    typedef enum logic [10:0] {
        S_CLR    = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_LOOKUP = 11'b000_0000_0100,
        S_CHECK  = 11'b000_0000_1000,
        S_LAST   = 11'b000_0001_0000,
        S_SD_RD  = 11'b000_0010_0000,
        S_SD_CMP = 11'b000_0100_0000,
        S_SU_RD  = 11'b000_1000_0000,
        S_SU_CMP = 11'b001_0000_0000,
        S_FIN    = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass of the position table.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencing of one operation and the command to the datapath.
    always_comb begin
        state_next = state_reg;
        cmd        = CMD_IDLE;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                cmd = CMD_CLR;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                cmd        = CMD_LOOKUP;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd = CMD_CHECK;
                priority if (stat.chk_last) begin
                    state_next = S_LAST;
                end else if (stat.chk_down) begin
                    state_next = S_SD_RD;
                end else if (stat.chk_up) begin
                    state_next = S_SU_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_LAST: begin
                cmd        = CMD_LAST;
                state_next = S_SD_RD;
            end
            S_SD_RD: begin
                cmd        = CMD_SD_RD;
                state_next = stat.sd_end ? S_SU_RD : S_SD_CMP;
            end
            S_SD_CMP: begin
                cmd = CMD_SD_CMP;
                if (stat.sd_swap && !stat.sd_one) begin
                    state_next = S_SD_RD;
                end else begin
                    state_next = S_SU_RD;
                end
            end
            S_SU_RD: begin
                cmd        = CMD_SU_RD;
                state_next = stat.su_top ? S_FIN : S_SU_CMP;
            end
            S_SU_CMP: begin
                cmd        = CMD_SU_CMP;
                state_next = stat.su_swap ? S_SU_RD : S_FIN;
            end
            S_FIN: begin
                cmd        = CMD_FIN;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd        = CMD_DONE;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/iph_dp.sv
module iph_dp #(
    parameter int GAIN_BITS  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  iph_pkg::cmd_t                 cmd,
    input  iph_pkg::func_t                in_func,
    input  logic [iph_pkg::NODE_W-1:0]    in_node,
    input  logic [GAIN_BITS-1:0]          in_gain,
    input  logic [iph_pkg::CNT_W-1:0]     cap,
    input  logic                          m_tready,
    output iph_pkg::dp_stat_t             stat,
    output logic                          out_valid,
    output logic [iph_pkg::NODE_W-1:0]    out_node,
    output logic [GAIN_BITS-1:0]          out_gain,
    output logic [iph_pkg::STAT_W-1:0]    out_status,
    output logic [iph_pkg::CNT_W-1:0]     out_count
);
    import iph_pkg::*;

    localparam int SW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int NW = $clog2(NODE_COUNT);

    // Heap slots (node and gain) and the slot of every node.
    logic [NODE_W-1:0]    slot_node_mem [HEAP_DEPTH];
    logic [GAIN_BITS-1:0] slot_gain_mem [HEAP_DEPTH];
    logic [CW-1:0]        pos_mem       [NODE_COUNT];

    func_t                func_reg;
    logic [NODE_W-1:0]    node_reg;
    logic [GAIN_BITS-1:0] gain_reg;
    logic [CW-1:0]        pos_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        p_reg;
    logic [NODE_W-1:0]    mv_node_reg;
    logic [GAIN_BITS-1:0] mv_gain_reg;
    logic [NODE_W-1:0]    rda_node_reg;
    logic [GAIN_BITS-1:0] rda_gain_reg;
    logic [NODE_W-1:0]    rdb_node_reg;
    logic [GAIN_BITS-1:0] rdb_gain_reg;
    logic [NODE_W-1:0]    res_node_reg;
    logic [GAIN_BITS-1:0] res_gain_reg;
    logic [STAT_W-1:0]    res_stat_reg;
    logic [NW-1:0]        clr_reg;
    logic                 out_valid_reg;
    logic [NODE_W-1:0]    out_node_reg;
    logic [GAIN_BITS-1:0] out_gain_reg;
    logic [STAT_W-1:0]    out_stat_reg;
    logic [CNT_W-1:0]     out_cnt_reg;

    logic [CW:0]          l_w;
    logic [CW:0]          r_w;
    logic [CW:0]          cnt_x;
    logic [CW-1:0]        up_w;
    logic [CW-1:0]        cnt_dec;
    logic [CW-1:0]        take_p;
    logic [31:0]          cap_w;
    logic                 known;
    logic                 present;
    logic                 full;
    logic                 empty;
    logic                 take;
    logic                 pick_r;
    logic [NODE_W-1:0]    pick_node;
    logic [GAIN_BITS-1:0] pick_gain;
    logic [CW-1:0]        pick_idx;
    logic [SW-1:0]        addr_a;
    logic [SW-1:0]        addr_b;
    logic                 slot_we;
    logic [NODE_W-1:0]    slot_wnode;
    logic [GAIN_BITS-1:0] slot_wgain;
    logic                 pos_we;
    logic [NW-1:0]        pos_waddr;
    logic [CW-1:0]        pos_wdata;

    // Tree arithmetic around the current hole.
    assign cnt_x   = {1'b0, cnt_reg};
    assign l_w     = {p_reg, 1'b0} + (CW+1)'(1);
    assign r_w     = l_w + (CW+1)'(1);
    assign up_w    = (p_reg - CW'(1)) >> 1;
    assign cnt_dec = cnt_reg - CW'(1);

    // Decisions taken when the lookup data is back.
    assign cap_w   = (32'(cap) > 32'(HEAP_DEPTH)) ? 32'(HEAP_DEPTH) : 32'(cap);
    assign known   = 32'(node_reg) < 32'(NODE_COUNT);
    assign present = (pos_reg < cnt_reg) && (rda_node_reg == node_reg);
    assign full    = 32'(cnt_reg) >= cap_w;
    assign empty   = (cnt_reg == '0);
    assign take    = ((func_reg == FN_POP) && !empty)
                   || ((func_reg == FN_REMOVE) && known && present);
    assign take_p  = (func_reg == FN_POP) ? '0 : pos_reg;

    // Larger child; equal gains favor the right child when it exists.
    assign pick_r    = (r_w != cnt_x) && !(rda_gain_reg > rdb_gain_reg);
    assign pick_node = pick_r ? rdb_node_reg : rda_node_reg;
    assign pick_gain = pick_r ? rdb_gain_reg : rda_gain_reg;
    assign pick_idx  = pick_r ? CW'(r_w) : CW'(l_w);

    always_comb begin
        stat          = '0;
        stat.clr_last = (clr_reg == NW'(NODE_COUNT - 1));
        stat.chk_last = take && (cnt_dec > take_p);
        stat.chk_down = (func_reg == FN_UPDATE) && known && present;
        stat.chk_up   = (func_reg == FN_INSERT) && known && !present && !full;
        stat.sd_end   = r_w > cnt_x;
        stat.sd_one   = r_w == cnt_x;
        stat.sd_swap  = pick_gain > mv_gain_reg;
        stat.su_top   = (p_reg == '0);
        stat.su_swap  = mv_gain_reg > rda_gain_reg;
        stat.out_free = !out_valid_reg || m_tready;
    end

    // Slot read addresses.
    always_comb begin
        unique case (cmd)
            CMD_LOOKUP: addr_a = (func_reg == FN_POP) ? '0 : SW'(pos_reg);
            CMD_CHECK:  addr_a = SW'(cnt_dec);
            CMD_SD_RD:  addr_a = SW'(l_w);
            default:    addr_a = SW'(up_w);
        endcase
        addr_b = SW'(r_w);
    end

    // Slot and position write ports.
    always_comb begin
        slot_we    = 1'b0;
        slot_wnode = mv_node_reg;
        slot_wgain = mv_gain_reg;
        pos_we     = 1'b0;
        pos_waddr  = NW'(mv_node_reg);
        pos_wdata  = p_reg;
        unique case (cmd)
            CMD_SD_CMP: begin
                slot_we    = stat.sd_swap;
                slot_wnode = pick_node;
                slot_wgain = pick_gain;
                pos_we     = stat.sd_swap;
                pos_waddr  = NW'(pick_node);
            end
            CMD_SU_CMP: begin
                slot_we    = stat.su_swap;
                slot_wnode = rda_node_reg;
                slot_wgain = rda_gain_reg;
                pos_we     = stat.su_swap;
                pos_waddr  = NW'(rda_node_reg);
            end
            CMD_FIN: begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
            end
            CMD_CLR: begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = CW'(HEAP_DEPTH);
            end
            default: begin
            end
        endcase
    end

    // Slot memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_node_mem[SW'(p_reg)] <= slot_wnode;
            slot_gain_mem[SW'(p_reg)] <= slot_wgain;
        end
        rda_node_reg <= slot_node_mem[addr_a];
        rda_gain_reg <= slot_gain_mem[addr_a];
        rdb_node_reg <= slot_node_mem[addr_b];
        rdb_gain_reg <= slot_gain_mem[addr_b];
    end

    // Position memory: one write port, read when a beat is taken.
    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (cmd == CMD_LOAD) begin
            pos_reg <= pos_mem[NW'(in_node)];
        end
    end

    // Control state: heap count, clearing pointer, result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd == CMD_CLR) begin
                clr_reg <= clr_reg + NW'(1);
            end
            if (cmd == CMD_CHECK) begin
                if (stat.chk_up) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end else if (take) begin
                    cnt_reg <= cnt_dec;
                end else if (func_reg == FN_CLEAR) begin
                    cnt_reg <= '0;
                end
            end
            if (cmd == CMD_DONE) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operation registers, moving item and result.
    always_ff @(posedge aclk) begin
        unique case (cmd)
            CMD_LOAD: begin
                func_reg     <= in_func;
                node_reg     <= in_node;
                gain_reg     <= in_gain;
                res_node_reg <= '0;
                res_gain_reg <= '0;
                res_stat_reg <= ST_DONE;
            end
            CMD_CHECK: begin
                unique case (func_reg)
                    FN_INSERT: begin
                        if (!known) begin
                            res_stat_reg <= ST_ABSENT;
                        end else if (present) begin
                            res_stat_reg <= ST_PRESENT;
                        end else if (full) begin
                            res_stat_reg <= ST_FULL;
                        end else begin
                            mv_node_reg <= node_reg;
                            mv_gain_reg <= gain_reg;
                            p_reg       <= cnt_reg;
                        end
                    end
                    FN_POP: begin
                        if (empty) begin
                            res_stat_reg <= ST_EMPTY;
                        end else begin
                            res_node_reg <= rda_node_reg;
                            res_gain_reg <= rda_gain_reg;
                            p_reg        <= '0;
                        end
                    end
                    FN_REMOVE: begin
                        if (!known || !present) begin
                            res_stat_reg <= ST_ABSENT;
                        end else begin
                            p_reg <= pos_reg;
                        end
                    end
                    FN_UPDATE: begin
                        if (!known) begin
                            res_stat_reg <= ST_ABSENT;
                        end else if (present) begin
                            mv_node_reg <= node_reg;
                            mv_gain_reg <= gain_reg;
                            p_reg       <= pos_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_LAST: begin
                mv_node_reg <= rda_node_reg;
                mv_gain_reg <= rda_gain_reg;
            end
            CMD_SD_CMP: begin
                if (stat.sd_swap) begin
                    p_reg <= pick_idx;
                end
            end
            CMD_SU_CMP: begin
                if (stat.su_swap) begin
                    p_reg <= up_w;
                end
            end
            CMD_DONE: begin
                out_node_reg <= res_node_reg;
                out_gain_reg <= res_gain_reg;
                out_stat_reg <= res_stat_reg;
                out_cnt_reg  <= CNT_W'(cnt_reg);
            end
            default: begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_node   = out_node_reg;
    assign out_gain   = out_gain_reg;
    assign out_status = out_stat_reg;
    assign out_count  = out_cnt_reg;

endmodule

### src/indexed_priority_heap.sv
// Addressable binary max-heap of node ids keyed by gain, largest gain on top.
// After reset the block sweeps its node position table and accepts no beat
// until that pass is done; capacity writes are taken at any time. Each
// operation then runs one at a time through a controller and a datapath with
// single-write, two-read slot memory: the accepting step, the position lookup
// and the checks, a refill of the hole from the last slot for a pop or remove,
// for each sift-down level a read of both children and then a compare and
// move, for each sift-up level a read of the parent and then a compare and
// move, then the placing of the moving node and the hand-over of the result
// to the output register. The longest case is a pop from a full 1024-entry
// heap whose refill sinks to a leaf.
module indexed_priority_heap #(
    parameter int GAIN_BITS  = 32,
    localparam int IN_W  = ((iph_pkg::NODE_W + GAIN_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((iph_pkg::NODE_W + GAIN_BITS + iph_pkg::CNT_W + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_W-1:0]            s_tdata,   // node_id, gain
    input  logic [iph_pkg::FUNC_W-1:0] s_tuser,   // func
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_W-1:0]           m_tdata,   // result_node, result_gain, count
    output logic [iph_pkg::STAT_W-1:0] m_tuser,   // status
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [iph_pkg::CNT_W-1:0]  cfg_data
);
    import iph_pkg::*;

    cmd_t                 cmd;
    dp_stat_t             stat;
    logic [CNT_W-1:0]     cap_reg;
    logic [NODE_W-1:0]    out_node;
    logic [GAIN_BITS-1:0] out_gain;
    logic [CNT_W-1:0]     out_count;

    // Capacity register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    iph_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iph_dp #(
        .GAIN_BITS  (GAIN_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_func    (func_t'(s_tuser)),
        .in_node    (s_tdata[NODE_W-1:0]),
        .in_gain    (s_tdata[NODE_W +: GAIN_BITS]),
        .cap        (cap_reg),
        .m_tready   (m_tready),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_node   (out_node),
        .out_gain   (out_gain),
        .out_status (m_tuser),
        .out_count  (out_count)
    );

    // Result beat packing.
    assign m_tdata = OUT_W'({out_count, out_gain, out_node});

endmodule

### src/iph_checker.sv
`include "indexed_priority_heap_defines.svh"

module iph_checker #(
    parameter int GAIN_BITS  = 32,
    parameter int OUT_W      = 56
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [OUT_W-1:0]           m_tdata,
    input logic [iph_pkg::STAT_W-1:0] m_tuser
);
    import iph_pkg::*;

    // Reset leaves no result beat pending.
    `IPH_ASSERT_ALWAYS_NEXT(a_rst_idle, !aresetn, !m_tvalid, "result valid after reset")

    // A stalled result beat keeps its contents.
    `IPH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Only a successful pop carries a node and a gain.
    `IPH_ASSERT(a_zero_res, m_tvalid && (m_tuser != ST_DONE), (m_tdata[NODE_W-1:0] == '0) && (m_tdata[NODE_W +: GAIN_BITS] == '0), "refused operation returned data")

    // The count never exceeds the slot memory.
    `IPH_ASSERT(a_cnt_range, m_tvalid, 32'(m_tdata[NODE_W + GAIN_BITS +: CNT_W]) <= 32'(HEAP_DEPTH), "count beyond heap depth")

endmodule

bind indexed_priority_heap iph_checker #(
    .GAIN_BITS  (GAIN_BITS),
    .OUT_W      (OUT_W)
) u_iph_checker (.*);
